[rtl/csd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// csd_pkg: charger status and current decode definitions
// Types, codes, decode tables and the divider step shared by the csd modules.
// ----------------------------------------------------------------------------
package csd_pkg;

  localparam int unsigned InW   = 32;
  localparam int unsigned OutW  = 32;
  localparam int unsigned MvW   = 14;
  localparam int unsigned WorkW = 10;
  localparam int unsigned LimW  = 11;
  localparam int unsigned QuoW  = 9;
  localparam int unsigned RemW  = 21;
  localparam int unsigned ShW   = MvW + QuoW;

  localparam logic [RemW-1:0] EstPower = RemW'(1200000);
  localparam logic [MvW-1:0]  MinEstMv = MvW'(2500);

  localparam logic [1:0] CfgPrecharge  = 2'd0;
  localparam logic [1:0] CfgFastcharge = 2'd1;
  localparam logic [1:0] CfgTerminate  = 2'd2;
  localparam logic [1:0] CfgInputLimit = 2'd3;

  localparam logic [1:0] DirStandby   = 2'd0;
  localparam logic [1:0] DirCharge    = 2'd1;
  localparam logic [1:0] DirDischarge = 2'd2;

  localparam logic [2:0] PhTrickle     = 3'd0;
  localparam logic [2:0] PhPre         = 3'd1;
  localparam logic [2:0] PhCc          = 3'd2;
  localparam logic [2:0] PhCv          = 3'd3;
  localparam logic [2:0] PhFull        = 3'd4;
  localparam logic [2:0] PhNotCharging = 3'd5;
  localparam logic [2:0] PhDischarging = 3'd6;
  localparam logic [2:0] PhStandby     = 3'd7;

  localparam logic [1:0] BatAbsent      = 2'd0;
  localparam logic [1:0] BatCharged     = 2'd1;
  localparam logic [1:0] BatCharging    = 2'd2;
  localparam logic [1:0] BatDischarging = 2'd3;

  localparam logic [WorkW-1:0] TrickleMa = WorkW'(10);
  localparam logic [WorkW-1:0] TermMaxMa = WorkW'(200);

  localparam logic [LimW-1:0] LimitTab [8] = '{
    LimW'(100), LimW'(500), LimW'(900), LimW'(1000),
    LimW'(1500), LimW'(2000), LimW'(0), LimW'(0)
  };

  typedef struct packed {
    logic [1:0]       direction;
    logic [2:0]       phase_code;
    logic [WorkW-1:0] work_ma;
    logic [LimW-1:0]  limit_ma;
    logic             thermal_flag;
    logic             estimated;
    logic [1:0]       battery_state;
    logic [MvW-1:0]   battery_mv;
    logic             div_en;
  } pkt_t;

  typedef struct packed {
    pkt_t            pkt;
    logic [RemW-1:0] rem;
    logic [QuoW-1:0] quo;
  } div_stage_t;

  function automatic logic [WorkW-1:0] times25(input logic [4:0] n);
    logic [WorkW-1:0] w;
    w = WorkW'(n);
    return (w << 4) + (w << 3) + w;
  endfunction

  function automatic div_stage_t div_step(input div_stage_t s, input int unsigned k);
    div_stage_t r;
    logic [ShW-1:0] sh;
    r  = s;
    sh = ShW'(s.pkt.battery_mv) << k;
    if ({2'b00, s.rem} >= sh) begin
      r.rem    = s.rem - sh[RemW-1:0];
      r.quo[k] = 1'b1;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/csd_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// csd_front: status classifier
// Holds the charge-setting registers and decodes each request into a packet.
// ----------------------------------------------------------------------------
module csd_front
  import csd_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire logic [1:0]     cfg_idx_i,
  input  wire logic [7:0]     cfg_wdata_i,
  input  wire logic [InW-1:0] req_data_i,
  output pkt_t                pkt_o
);

  logic [7:0] pre_q, fast_q, term_q, lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_q  <= '0;
      fast_q <= '0;
      term_q <= '0;
      lim_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgPrecharge:  pre_q  <= cfg_wdata_i;
        CfgFastcharge: fast_q <= cfg_wdata_i;
        CfgTerminate:  term_q <= cfg_wdata_i;
        CfgInputLimit: lim_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [7:0]       st1, st2;
  logic [MvW-1:0]   mv;
  logic             good;
  logic [1:0]       raw_dir, dir;
  logic [2:0]       phase;
  logic [WorkW-1:0] pre_ma, cc_ma, term_ma;
  logic [4:0]       cc_n;

  assign st1  = req_data_i[7:0];
  assign st2  = req_data_i[15:8];
  assign mv   = req_data_i[29:16];
  assign good = req_data_i[30];

  assign raw_dir = st2[6:5];
  assign phase   = st2[2:0];
  assign cc_n    = fast_q[4:0];

  always_comb begin
    unique case (raw_dir)
      DirCharge:    dir = DirCharge;
      DirDischarge: dir = DirDischarge;
      default:      dir = DirStandby;
    endcase
  end

  assign pre_ma  = (pre_q[3:0] > 4'd8) ? '0 : times25({1'b0, pre_q[3:0]});
  assign term_ma = (term_q[3:0] > 4'd8) ? TermMaxMa : times25({1'b0, term_q[3:0]});

  always_comb begin
    if (cc_n == 5'd0 || cc_n > 5'd16) begin
      cc_ma = '0;
    end else if (cc_n <= 5'd8) begin
      cc_ma = times25(cc_n);
    end else begin
      cc_ma = TermMaxMa + WorkW'(cc_n - 5'd8) * WorkW'(100);
    end
  end

  always_comb begin
    pkt_o              = '0;
    pkt_o.direction    = dir;
    pkt_o.limit_ma     = good ? LimitTab[lim_q[2:0]] : '0;
    pkt_o.thermal_flag = st1[1];
    pkt_o.battery_mv   = mv;
    if (dir == DirCharge || !phase[2]) begin
      unique case (phase)
        PhTrickle: begin pkt_o.work_ma = TrickleMa; pkt_o.phase_code = PhTrickle; end
        PhPre:     begin pkt_o.work_ma = pre_ma;    pkt_o.phase_code = PhPre;     end
        PhCc:      begin pkt_o.work_ma = cc_ma;     pkt_o.phase_code = PhCc;      end
        PhCv:      begin pkt_o.work_ma = term_ma;   pkt_o.phase_code = PhCv;      end
        PhFull:    pkt_o.phase_code = PhFull;
        default:   pkt_o.phase_code = PhNotCharging;
      endcase
    end else if (dir == DirDischarge) begin
      pkt_o.phase_code = PhDischarging;
      pkt_o.estimated  = 1'b1;
      pkt_o.div_en     = (mv > MinEstMv);
    end else begin
      pkt_o.phase_code = PhStandby;
    end
    if (!st1[3]) begin
      pkt_o.battery_state = BatAbsent;
    end else if (phase == PhFull) begin
      pkt_o.battery_state = BatCharged;
    end else if (!phase[2]) begin
      pkt_o.battery_state = BatCharging;
    end else begin
      pkt_o.battery_state = BatDischarging;
    end
  end

endmodule
`default_nettype wire

[rtl/csd_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// csd_fifo: packet queue
// Short queue between the classifier and the divider pipeline.
// ----------------------------------------------------------------------------
module csd_fifo
  import csd_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  pkt_t      push_pkt_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output pkt_t      pop_pkt_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  pkt_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign pop_pkt_o = mem_q[rd_q];

  assign wr_d  = do_push ? ((wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1) : wr_q;
  assign rd_d  = do_pop ? ((rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1) : rd_q;
  assign cnt_d = cnt_q + CntW'(do_push) - CntW'(do_pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_pkt_i;
    end
  end

endmodule
`default_nettype wire

[rtl/csd_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// csd_back: divider pipeline
// Radix-2 restoring divide of the discharge power by the battery voltage,
// one quotient bit per stage, elastic stalls, last stage is the output register.
// ----------------------------------------------------------------------------
module csd_back
  import csd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  pkt_t      in_pkt_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output pkt_t      out_pkt_o
);

  localparam int unsigned NStg = QuoW;

  div_stage_t       stg_q [NStg];
  div_stage_t       stg_d [NStg];
  logic [NStg-1:0]  vld_q;
  logic [NStg-1:0]  vld_in;
  logic [NStg-1:0]  rdy;
  div_stage_t       load;

  always_comb begin
    load     = '0;
    load.pkt = in_pkt_i;
    load.rem = EstPower;
  end

  assign rdy[NStg-1] = !vld_q[NStg-1] || out_ready_i;
  assign stg_d[0]    = div_step(load, NStg - 1);
  assign vld_in      = {vld_q[NStg-2:0], in_valid_i};

  for (genvar i = 0; i < NStg; i++) begin : g_stg
    if (i < NStg - 1) begin : g_rdy
      assign rdy[i] = !vld_q[i] || rdy[i+1];
    end
    if (i > 0) begin : g_step
      assign stg_d[i] = div_step(stg_q[i-1], NStg - 1 - i);
    end

    always_ff @(posedge clk_i) begin
      if (rdy[i]) begin
        stg_q[i] <= stg_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int i = 0; i < NStg; i++) begin
        if (rdy[i]) begin
          vld_q[i] <= vld_in[i];
        end
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NStg-1];

  always_comb begin
    out_pkt_o = stg_q[NStg-1].pkt;
    if (stg_q[NStg-1].pkt.estimated) begin
      out_pkt_o.work_ma = stg_q[NStg-1].pkt.div_en ? WorkW'(stg_q[NStg-1].quo) : '0;
    end
  end

  a_quo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && stg_q[NStg-1].pkt.div_en) |-> (stg_q[NStg-1].quo <= QuoW'(479)))
    else $error("discharge estimate out of range");

  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && stg_q[NStg-1].pkt.div_en)
      |-> (stg_q[NStg-1].rem < RemW'(stg_q[NStg-1].pkt.battery_mv)))
    else $error("divider remainder not reduced");

  a_est_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_pkt_o.estimated) |-> (out_pkt_o.phase_code == PhDischarging))
    else $error("estimate outside discharge phase");

endmodule
`default_nettype wire

[rtl/charge_status_current_decode_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// charge_status_current_decode_top: charger status and current decoder
// Decodes charger status bytes into direction, phase, currents and flags.
// ----------------------------------------------------------------------------
// Path: the queue stores each accepted request and hands it to the first of
// nine divider stages; the last stage is the output register.
// Throughput: one request per cycle unless stalled; the divider pipeline sets it.
// Output stalls fill the divider stages, then the queue, then drop s_axis_tready.
// Reset clears the queue, the pipeline valid bits and the setting registers to 0.
// ----------------------------------------------------------------------------
module charge_status_current_decode_top
  import csd_pkg::*;
#(
  parameter int unsigned FifoDepth = 4
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [1:0]      cfg_idx_i,
  input  wire logic [7:0]      cfg_wdata_i,
  input  wire logic            s_axis_tvalid,
  output logic                 s_axis_tready,
  // status_one[7:0], status_two[15:8], battery_mv[29:16], supply_good[30], pad[31]
  input  wire logic [InW-1:0]  s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  wire logic            m_axis_tready,
  // direction[1:0], phase_code[4:2], work_ma[14:5], limit_ma[25:15],
  // thermal_flag[26], estimated[27], battery_state[29:28], pad[31:30]
  output logic [OutW-1:0]      m_axis_tdata
);

  pkt_t front_pkt, q_pkt, out_pkt;
  logic q_full, q_empty, back_rdy;

  csd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_data_i  (s_axis_tdata),
    .pkt_o       (front_pkt)
  );

  csd_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (s_axis_tvalid),
    .push_pkt_i (front_pkt),
    .full_o     (q_full),
    .pop_i      (back_rdy),
    .empty_o    (q_empty),
    .pop_pkt_o  (q_pkt)
  );

  csd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (!q_empty),
    .in_pkt_i    (q_pkt),
    .in_ready_o  (back_rdy),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_pkt_o   (out_pkt)
  );

  assign s_axis_tready = !q_full;

  assign m_axis_tdata = {2'b00, out_pkt.battery_state, out_pkt.estimated,
                         out_pkt.thermal_flag, out_pkt.limit_ma, out_pkt.work_ma,
                         out_pkt.phase_code, out_pkt.direction};

endmodule
`default_nettype wire
